FILE: design/mexp_pkg.sv
// Package for the modular exponentiation unit.
// Holds widths, register addresses, microcode types and the microcode ROM.
// No dependencies.
package mexp_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned PROD_W      = 2 * WORD_W;
  localparam int unsigned EXP_BITS    = 32;
  localparam int unsigned BIT_CNT_W   = $clog2(EXP_BITS + 1);
  localparam int unsigned RED_CNT_W   = $clog2(PROD_W);
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PC_W        = 4;
  localparam int unsigned ROM_DEPTH   = 14;

  localparam logic [WORD_W-1:0] MODULUS_RESET = 32'd1000000007;
  localparam logic              REG_MODULUS   = 1'b0;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RED_BASE,
    OP_WB_SQ,
    OP_MUL_ACC,
    OP_MUL_SQ,
    OP_RED_PROD,
    OP_WB_ACC,
    OP_NEXT_BIT,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_INPUT,
    C_RED_BUSY,
    C_LOOP_END,
    C_BIT_CLR,
    C_OUT_FULL
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } cw_t;

  typedef struct packed {
    logic in_valid;
    logic red_busy;
    logic loop_end;
    logic bit_clr;
    logic out_full;
  } status_t;

  localparam logic [PC_W-1:0] PC_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] PC_WAIT_B = 4'd2;
  localparam logic [PC_W-1:0] PC_LOOP   = 4'd3;
  localparam logic [PC_W-1:0] PC_MUL_SQ = 4'd8;
  localparam logic [PC_W-1:0] PC_WAIT_A = 4'd7;
  localparam logic [PC_W-1:0] PC_WAIT_S = 4'd10;
  localparam logic [PC_W-1:0] PC_FINISH = 4'd12;

  function automatic cw_t rom_word(logic [PC_W-1:0] pc);
    cw_t w;
    w = '{op: OP_NONE, cond: C_ALWAYS, target: PC_IDLE};
    case (pc)
      4'd0:    w = '{op: OP_LOAD,     cond: C_NO_INPUT, target: PC_IDLE};
      4'd1:    w = '{op: OP_RED_BASE, cond: C_NEXT,     target: PC_IDLE};
      4'd2:    w = '{op: OP_WB_SQ,    cond: C_RED_BUSY, target: PC_WAIT_B};
      4'd3:    w = '{op: OP_NONE,     cond: C_LOOP_END, target: PC_FINISH};
      4'd4:    w = '{op: OP_NONE,     cond: C_BIT_CLR,  target: PC_MUL_SQ};
      4'd5:    w = '{op: OP_MUL_ACC,  cond: C_NEXT,     target: PC_IDLE};
      4'd6:    w = '{op: OP_RED_PROD, cond: C_NEXT,     target: PC_IDLE};
      4'd7:    w = '{op: OP_WB_ACC,   cond: C_RED_BUSY, target: PC_WAIT_A};
      4'd8:    w = '{op: OP_MUL_SQ,   cond: C_NEXT,     target: PC_IDLE};
      4'd9:    w = '{op: OP_RED_PROD, cond: C_NEXT,     target: PC_IDLE};
      4'd10:   w = '{op: OP_WB_SQ,    cond: C_RED_BUSY, target: PC_WAIT_S};
      4'd11:   w = '{op: OP_NEXT_BIT, cond: C_ALWAYS,   target: PC_LOOP};
      4'd12:   w = '{op: OP_EMIT,     cond: C_OUT_FULL, target: PC_FINISH};
      4'd13:   w = '{op: OP_NONE,     cond: C_ALWAYS,   target: PC_IDLE};
      default: w = '{op: OP_NONE,     cond: C_ALWAYS,   target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: design/mexp_reducer.sv
// Iterative 64-by-32 remainder unit, one quotient bit per cycle.
// A modulus of zero stands for 2^32 and returns the low word at once.
// Depends on mexp_pkg.
module mexp_reducer
  import mexp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] value,
  input  logic [WORD_W-1:0] modulus,
  output logic              busy,
  output logic [WORD_W-1:0] result
);

  logic [PROD_W-1:0]    shreg;
  logic [WORD_W-1:0]    rem;
  logic [RED_CNT_W-1:0] cnt;
  logic [WORD_W:0]      trial;
  logic                 fits;

  assign trial  = {rem, shreg[PROD_W-1]};
  assign fits   = trial >= {1'b0, modulus};
  assign result = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= (modulus != '0);
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= value;
      cnt   <= RED_CNT_W'(PROD_W - 1);
      rem   <= (modulus == '0) ? value[WORD_W-1:0] : '0;
    end else if (busy) begin
      shreg <= {shreg[PROD_W-2:0], 1'b0};
      cnt   <= cnt - 1'b1;
      rem   <= fits ? WORD_W'(trial - {1'b0, modulus}) : trial[WORD_W-1:0];
    end
  end

endmodule

FILE: design/mexp_sequencer.sv
// Microcode sequencer: step counter, ROM fetch and conditional jumps.
// Depends on mexp_pkg.
module mexp_sequencer
  import mexp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output cw_t     cw
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            take;

  assign cw = rom_word(pc);

  always_comb begin
    case (cw.cond)
      C_NEXT:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_INPUT: take = !status.in_valid;
      C_RED_BUSY: take = status.red_busy;
      C_LOOP_END: take = status.loop_end;
      C_BIT_CLR:  take = status.bit_clr;
      C_OUT_FULL: take = status.out_full;
      default:    take = 1'b1;
    endcase
  end

  always_comb begin
    if (take) begin
      pc_next = cw.target;
    end else if (pc == PC_W'(ROM_DEPTH - 1)) begin
      pc_next = PC_IDLE;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

FILE: design/modular_exponentiation_unit.sv
// Modular exponentiation unit: base^exponent mod modulus, right-to-left square-and-multiply.
// Each 64-step reduction holds the sequencer until it is done. One item at a time: the
// next item is taken at the LOAD step after the result is registered and an idle step,
// later if the output stalls.
// Synchronous reset: modulus returns to 1000000007, sequencer idles, output empties.
// Depends on mexp_pkg, mexp_sequencer and mexp_reducer.
module modular_exponentiation_unit
  import mexp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [WORD_W-1:0]  base_value,
  input  logic [WORD_W-1:0]  exponent,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [WORD_W-1:0]  power_result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [WORD_W-1:0]  pwdata,
  output logic [WORD_W-1:0]  prdata,
  output logic               pready
);

  logic [WORD_W-1:0]    modulus;
  logic [WORD_W-1:0]    acc;
  logic [WORD_W-1:0]    sq;
  logic [WORD_W-1:0]    exp_reg;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [PROD_W-1:0]    prod;
  logic                 out_free;
  logic                 in_accept;
  logic                 red_start;
  logic                 red_busy;
  logic [WORD_W-1:0]    red_result;
  logic [PROD_W-1:0]    red_value;
  cw_t                  cw;
  status_t              status;

  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_MODULUS) ? modulus : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (psel && penable && pwrite && paddr[PADDR_W-1] == REG_MODULUS) begin
      modulus <= pwdata;
    end
  end

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (cw.op != OP_LOAD);
  assign in_accept = in_valid && !in_stall;
  assign red_start = (cw.op == OP_RED_BASE) || (cw.op == OP_RED_PROD);
  assign red_value = (cw.op == OP_RED_BASE) ? {{WORD_W{1'b0}}, sq} : prod;

  assign status.in_valid = in_valid;
  assign status.red_busy = red_busy;
  assign status.loop_end = (exp_reg == '0) || (bit_cnt == BIT_CNT_W'(EXP_BITS));
  assign status.bit_clr  = !exp_reg[0];
  assign status.out_full = !out_free;

  mexp_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cw     (cw)
  );

  mexp_reducer u_red (
    .clk     (clk),
    .rst     (rst),
    .start   (red_start),
    .value   (red_value),
    .modulus (modulus),
    .busy    (red_busy),
    .result  (red_result)
  );

  always_ff @(posedge clk) begin
    case (cw.op)
      OP_LOAD: begin
        if (in_accept) begin
          sq      <= base_value;
          exp_reg <= exponent;
          bit_cnt <= '0;
          acc     <= (modulus == WORD_W'(1)) ? '0 : WORD_W'(1);
        end
      end
      OP_WB_SQ: begin
        if (!red_busy) sq <= red_result;
      end
      OP_WB_ACC: begin
        if (!red_busy) acc <= red_result;
      end
      OP_MUL_ACC:  prod <= PROD_W'(acc) * PROD_W'(sq);
      OP_MUL_SQ:   prod <= PROD_W'(sq) * PROD_W'(sq);
      OP_NEXT_BIT: begin
        exp_reg <= exp_reg >> 1;
        bit_cnt <= bit_cnt + 1'b1;
      end
      OP_EMIT: begin
        if (out_free) power_result <= acc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.op == OP_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: design/mexp_checker.sv
// Port-level checks for the modular exponentiation unit, bound to the top level.
// Depends on modular_exponentiation_unit.
module mexp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] power_result
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(power_result))
    else $error("stalled result changed or dropped");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while previous item still in work");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in work");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output not empty after reset");

endmodule

bind modular_exponentiation_unit mexp_checker u_mexp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .power_result (power_result)
);

FILE: test/modular_exponentiation_unit_test.sv
// Testbench for modular_exponentiation_unit: directed table then random items, with an
// in-bench square-and-multiply predictor, random stalls on both sides and APB writes.
// Depends on mexp_pkg and the modular_exponentiation_unit RTL.
module modular_exponentiation_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mexp_pkg::*;

  localparam logic [PADDR_W-1:0] ADDR_MODULUS = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_SPARE   = 3'd4;
  localparam int NUM_ROWS   = 22;
  localparam int NUM_PHASES = 5;
  localparam int PHASE_ITEMS = 22;
  localparam int HOLD_AFTER = 60;
  localparam int HOLD_CYCLES = 5000;

  typedef struct packed {
    logic [WORD_W-1:0] modulus;
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] expo;
    logic              known;
    logic [WORD_W-1:0] answer;
  } vector_t;

  localparam vector_t ROWS [NUM_ROWS] = '{
    '{MODULUS_RESET, 32'd0, 32'd0, 1'b1, 32'd1},
    '{MODULUS_RESET, 32'd12345, 32'd0, 1'b1, 32'd1},
    '{MODULUS_RESET, 32'd0, 32'd5, 1'b1, 32'd0},
    '{MODULUS_RESET, 32'd1, 32'hFFFFFFFF, 1'b1, 32'd1},
    '{MODULUS_RESET, 32'd7, 32'd1, 1'b1, 32'd7},
    '{MODULUS_RESET, MODULUS_RESET, 32'd3, 1'b1, 32'd0},
    '{MODULUS_RESET, 32'hFFFFFFFF, 32'd1, 1'b0, 32'd0},
    '{MODULUS_RESET, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'd0},
    '{MODULUS_RESET, 32'd2, 32'h80000000, 1'b0, 32'd0},
    '{MODULUS_RESET, 32'd3, 32'h55555555, 1'b0, 32'd0},
    '{MODULUS_RESET, 32'hAAAAAAAA, 32'hAAAAAAAA, 1'b0, 32'd0},
    '{32'd2, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'd1},
    '{32'd2, 32'hFFFFFFFE, 32'd3, 1'b1, 32'd0},
    '{32'hFFFFFFFF, 32'hFFFFFFFE, 32'd2, 1'b1, 32'd1},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'd5, 1'b1, 32'd0},
    '{32'hFFFFFFFF, 32'h12345678, 32'hFFFFFFFF, 1'b0, 32'd0},
    // modulus one: everything is zero
    '{32'd1, 32'd0, 32'd0, 1'b1, 32'd0},
    '{32'd1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'd0},
    // modulus zero: wraps at 2^32
    '{32'd0, 32'hFFFFFFFF, 32'd2, 1'b1, 32'd1},
    '{32'd0, 32'd2, 32'd32, 1'b1, 32'd0},
    '{32'd0, 32'd3, 32'hFFFFFFFF, 1'b0, 32'd0},
    '{32'd0, 32'd0, 32'd0, 1'b1, 32'd1}
  };

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [WORD_W-1:0]  base_value;
  logic [WORD_W-1:0]  exponent;
  logic               out_valid;
  logic               out_stall;
  logic [WORD_W-1:0]  power_result;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [WORD_W-1:0]  pwdata;
  logic [WORD_W-1:0]  prdata;
  logic               pready;

  logic [WORD_W-1:0] pending_powers[$];
  logic [WORD_W-1:0] modulus_now;
  logic [WORD_W-1:0] want_power;
  int unsigned       mismatches;
  int unsigned       items_sent;
  bit                hold_done;

  modular_exponentiation_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .base_value   (base_value),
    .exponent     (exponent),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .power_result (power_result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [63:0] fold_mod(logic [63:0] x, logic [WORD_W-1:0] m);
    if (m == '0) begin
      return x & 64'h0000_0000_FFFF_FFFF;
    end
    return x % {32'd0, m};
  endfunction

  function automatic logic [WORD_W-1:0] power_mod(logic [WORD_W-1:0] b, logic [WORD_W-1:0] e,
                                                  logic [WORD_W-1:0] m);
    logic [63:0] sq;
    logic [63:0] acc;
    sq  = fold_mod({32'd0, b}, m);
    acc = fold_mod(64'd1, m);
    for (int i = 0; i < EXP_BITS && i < 64; i++) begin
      if (i < WORD_W && e[i]) begin
        acc = fold_mod(acc * sq, m);
      end
      sq = fold_mod(sq * sq, m);
    end
    return acc[WORD_W-1:0];
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WORD_W-1:0] random_base();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'd1;
      2: return modulus_now - 32'd1;
      3: return modulus_now;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] random_exponent();
    int unsigned w;
    case ($urandom_range(0, 7))
      0: return '0;
      1, 2: return $urandom();
      3: return 32'hFFFFFFFF;
      default: begin
        w = $urandom_range(1, 12);
        return $urandom_range(0, (1 << w) - 1);
      end
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] phase_modulus(int p);
    case (p)
      0: return $urandom();
      1: return $urandom_range(2, 1000);
      2: return MODULUS_RESET;
      3: return $urandom() | 32'h80000000;
      default: return $urandom_range(2, 65535);
    endcase
  endfunction

  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [WORD_W-1:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_read(input logic [PADDR_W-1:0] addr, output logic [WORD_W-1:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_modulus(input logic [WORD_W-1:0] want);
    logic [WORD_W-1:0] got;
    reg_read(ADDR_MODULUS, got);
    if (got !== want) begin
      $error("modulus: expected %0d, got %0d", want, got);
      mismatches++;
    end
  endtask

  // spare address must not disturb the modulus
  task automatic set_modulus(input logic [WORD_W-1:0] value);
    reg_write(ADDR_MODULUS, value);
    reg_write(ADDR_SPARE, $urandom());
    check_modulus(value);
    modulus_now = value;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_item(input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] e,
                           input logic typed, input logic [WORD_W-1:0] answer);
    int unsigned gap;
    in_valid   <= 1'b1;
    base_value <= b;
    exponent   <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_powers.push_back(typed ? answer : power_mod(b, e, modulus_now));
    items_sent++;
    gap = idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_powers.size() == 0) begin
        $error("power_result: no item expected, got %0d", power_result);
        mismatches++;
      end else begin
        want_power = pending_powers.pop_front();
        if (power_result !== want_power) begin
          $error("power_result: expected %0d, got %0d", want_power, power_result);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned n;
    out_stall = 1'b0;
    hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && items_sent >= HOLD_AFTER) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        n = idle_len();
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    base_value  = '0;
    exponent    = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    mismatches  = 0;
    items_sent  = 0;
    modulus_now = MODULUS_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    check_modulus(MODULUS_RESET);

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (ROWS[i].modulus != modulus_now) begin
        settle();
        set_modulus(ROWS[i].modulus);
      end
      send_item(ROWS[i].base, ROWS[i].expo, ROWS[i].known, ROWS[i].answer);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      set_modulus(phase_modulus(p));
      repeat (PHASE_ITEMS) send_item(random_base(), random_exponent(), 1'b0, '0);
    end

    settle();
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
design/mexp_pkg.sv
design/mexp_reducer.sv
design/mexp_sequencer.sv
design/modular_exponentiation_unit.sv
design/mexp_checker.sv
test/modular_exponentiation_unit_test.sv
